@@ design/top_k_heap_select_unit_assert.svh @@
// ----------------------------------------------------------------------------
// top_k_heap_select_unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef TOP_K_HEAP_SELECT_UNIT_ASSERT_SVH
`define TOP_K_HEAP_SELECT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// clocked check, disabled while reset is low
`define TKHS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check, always armed
`define TKHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TKHS_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TKHS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ design/tkhs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkhs_pkg
// shared types and codes of the top-k selection unit
// ----------------------------------------------------------------------------
package tkhs_pkg;

    // stream field widths
    localparam int IN_KEY_W  = 32;
    localparam int OUT_KEY_W = 32;

    // item kinds carried on s_axis_tuser
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W        = 1;
    localparam int   CFG_DATA_W       = 5;
    localparam logic CFG_KEEP_COUNT   = 1'b0;
    localparam logic CFG_KEEP_LARGEST = 1'b1;

    localparam logic [CFG_DATA_W-1:0] KEEP_COUNT_RST = 5'd16;

    // cell operations
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD        = 2'd0;
    localparam t_cell_op CELL_INSERT      = 2'd1;
    localparam t_cell_op CELL_REPLACE_LOW = 2'd2;
    localparam t_cell_op CELL_SHIFT_DOWN  = 2'd3;

    // per-cell control from the sequencer
    typedef struct packed {
        t_cell_op op;
        logic     occ;     // cell lies inside the live part of the chain
        logic     at_end;  // cell is the first one past the live part
    } t_cell_ctl;

    // per-cell compare results against the offered key
    typedef struct packed {
        logic gt_raw;  // stored key above offered key
        logic lt_raw;  // stored key below offered key
        logic gt;      // gt_raw for a live cell
        logic lt;      // lt_raw for a live cell
    } t_cell_flags;

endpackage

@@ design/tkhs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkhs_cell
// one slot of the ascending key chain: compares with the offered key and
// takes its own value, the key, or a neighbor's value
// ----------------------------------------------------------------------------
module tkhs_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                  i_clk,
    input  tkhs_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [KEY_BITS-1:0]   i_left_key,
    input  logic [KEY_BITS-1:0]   i_right_key,
    input  logic                  i_left_gt,
    input  logic                  i_right_lt,
    output logic [KEY_BITS-1:0]   o_key,
    output tkhs_pkg::t_cell_flags o_flags
);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                w_gt;
    logic                w_lt;

    assign w_gt = r_key > i_key;
    assign w_lt = r_key < i_key;

    assign o_flags.gt_raw = w_gt;
    assign o_flags.lt_raw = w_lt;
    assign o_flags.gt     = i_ctl.occ && w_gt;
    assign o_flags.lt     = i_ctl.occ && w_lt;
    assign o_key          = r_key;

    always_comb begin
        unique case (i_ctl.op)
            tkhs_pkg::CELL_INSERT: begin
                // larger keys move up one slot, the key lands in the gap
                if (i_left_gt) begin
                    n_key = i_left_key;
                end else if ((i_ctl.occ && w_gt) || i_ctl.at_end) begin
                    n_key = i_key;
                end else begin
                    n_key = r_key;
                end
            end
            tkhs_pkg::CELL_REPLACE_LOW: begin
                // bottom key drops out, smaller keys move down one slot
                if (i_right_lt) begin
                    n_key = i_right_key;
                end else if (i_ctl.occ && w_lt) begin
                    n_key = i_key;
                end else begin
                    n_key = r_key;
                end
            end
            tkhs_pkg::CELL_SHIFT_DOWN: n_key = i_right_key;
            default:                   n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

@@ design/top_k_heap_select_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_heap_select_unit
// keeps the best k keys of a stream in a sorted chain of cells and drains
// them best first
// ----------------------------------------------------------------------------
//  channel  direction  fields (low bit up)
//  s_axis   in         tuser: action   tdata: key
//  m_axis   out        tdata: out_key  tlast: last
//  cfg      in         index 0 keep_count, index 1 keep_largest
//
//  an insert beat is taken one per clock back to back while no drain runs
//  a drain of n keys blocks s_axis until its last key is loaded, one beat per
//  cycle, the drain sequencer loading the output register whenever it is free
//  a stalled m_axis holds the drain; inserts are taken while the last beat waits
//  reset clears the fill count, drain flag and output valid, sets the config
//  to defaults; the chain holds no reset and is never read beyond the fill count
// ----------------------------------------------------------------------------
`include "top_k_heap_select_unit_assert.svh"

module top_k_heap_select_unit #(
    parameter int MAX_KEEP = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tkhs_pkg::IN_KEY_W-1:0]     s_axis_tdata,   // key
    input  logic                              s_axis_tuser,   // action
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tkhs_pkg::OUT_KEY_W-1:0]    m_axis_tdata,   // out_key
    output logic                              m_axis_tlast,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [tkhs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tkhs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    // config and control registers
    logic [tkhs_pkg::CFG_DATA_W-1:0] r_keep_count;
    logic                            r_keep_largest;
    logic [CW-1:0]                   r_total;
    logic                            r_draining;
    logic                            r_out_valid;
    logic [tkhs_pkg::OUT_KEY_W-1:0]  r_out_key;
    logic                            r_out_last;

    logic [KEY_BITS-1:0]   w_key;
    logic [63:0]           w_in_wide;
    logic [63:0]           w_out_wide;
    logic [CW-1:0]         w_eff_k;
    logic                  w_full;
    logic                  w_in_acc;
    logic                  w_is_insert;
    logic                  w_load;
    logic [CW-1:0]         w_top_idx;
    logic [IW-1:0]         w_sel_idx;
    logic [KEY_BITS-1:0]   w_drain_key;
    logic                  w_do_grow;
    logic                  w_do_rep_hi;
    logic                  w_do_rep_lo;
    logic [CW-1:0]         w_fill;
    tkhs_pkg::t_cell_op    w_op;

    logic [KEY_BITS-1:0]   w_cell_key [MAX_KEEP];
    tkhs_pkg::t_cell_flags w_flags    [MAX_KEEP];
    tkhs_pkg::t_cell_ctl   w_ctl      [MAX_KEEP];

    assign w_in_wide = 64'(s_axis_tdata);
    assign w_key     = w_in_wide[KEY_BITS-1:0];

    // keep count of zero acts as one, above the chain length saturates
    always_comb begin
        if (r_keep_count == '0) begin
            w_eff_k = CW'(1);
        end else if (32'(r_keep_count) > 32'(MAX_KEEP)) begin
            w_eff_k = CW'(MAX_KEEP);
        end else begin
            w_eff_k = CW'(r_keep_count);
        end
    end

    assign w_full        = r_total >= w_eff_k;
    assign s_axis_tready = !r_draining;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_is_insert   = s_axis_tuser == tkhs_pkg::ACT_INSERT;
    assign w_load        = r_draining && (!r_out_valid || m_axis_tready);

    assign w_top_idx = r_total - CW'(1);
    assign w_sel_idx = w_top_idx[IW-1:0];

    // chain is ascending: worst is the top live cell when keeping smallest,
    // cell zero when keeping largest
    assign w_do_grow   = w_in_acc && w_is_insert && !w_full;
    assign w_do_rep_hi = w_in_acc && w_is_insert && w_full && !r_keep_largest
                         && w_flags[w_sel_idx].gt_raw;
    assign w_do_rep_lo = w_in_acc && w_is_insert && w_full && r_keep_largest
                         && w_flags[0].lt_raw;

    always_comb begin
        w_fill = r_total;
        w_op   = tkhs_pkg::CELL_HOLD;
        if (w_do_grow) begin
            w_op = tkhs_pkg::CELL_INSERT;
        end else if (w_do_rep_hi) begin
            // top key drops out, insert over the shortened chain
            w_op   = tkhs_pkg::CELL_INSERT;
            w_fill = w_top_idx;
        end else if (w_do_rep_lo) begin
            w_op = tkhs_pkg::CELL_REPLACE_LOW;
        end else if (w_load && !r_keep_largest) begin
            w_op = tkhs_pkg::CELL_SHIFT_DOWN;
        end
    end

    for (genvar gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
        logic [KEY_BITS-1:0] w_left_key;
        logic [KEY_BITS-1:0] w_right_key;
        logic                w_left_gt;
        logic                w_right_lt;

        if (gi == 0) begin : g_first
            assign w_left_key = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_mid_l
            assign w_left_key = w_cell_key[gi-1];
            assign w_left_gt  = w_flags[gi-1].gt;
        end

        if (gi == MAX_KEEP - 1) begin : g_last
            assign w_right_key = '0;
            assign w_right_lt  = 1'b0;
        end else begin : g_mid_r
            assign w_right_key = w_cell_key[gi+1];
            assign w_right_lt  = w_flags[gi+1].lt;
        end

        assign w_ctl[gi].op     = w_op;
        assign w_ctl[gi].occ    = CW'(gi) < w_fill;
        assign w_ctl[gi].at_end = CW'(gi) == w_fill;

        tkhs_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[gi]),
            .i_key       (w_key),
            .i_left_key  (w_left_key),
            .i_right_key (w_right_key),
            .i_left_gt   (w_left_gt),
            .i_right_lt  (w_right_lt),
            .o_key       (w_cell_key[gi]),
            .o_flags     (w_flags[gi])
        );
    end

    // smallest first drains from the bottom, largest first from the top
    assign w_drain_key = r_keep_largest ? w_cell_key[w_sel_idx] : w_cell_key[0];
    assign w_out_wide  = 64'(w_drain_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count   <= tkhs_pkg::KEEP_COUNT_RST;
            r_keep_largest <= 1'b0;
            r_total        <= '0;
            r_draining     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tkhs_pkg::CFG_KEEP_COUNT:   r_keep_count   <= i_cfg_wdata;
                    tkhs_pkg::CFG_KEEP_LARGEST: r_keep_largest <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (w_do_grow) begin
                r_total <= r_total + CW'(1);
            end else if (w_in_acc && !w_is_insert && r_total != '0) begin
                r_draining <= 1'b1;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_total     <= w_top_idx;
                if (r_total == CW'(1)) begin
                    r_draining <= 1'b0;
                end
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_key  <= w_out_wide[tkhs_pkg::OUT_KEY_W-1:0];
            r_out_last <= r_total == CW'(1);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_key;
    assign m_axis_tlast  = r_out_last;

    // checks
    `TKHS_ASSERT_RST(a_total_bound, i_clk, i_rst_n, r_total <= CW'(MAX_KEEP), "fill count above chain length")
    `TKHS_ASSERT_RST(a_drain_nonempty, i_clk, i_rst_n, r_draining |-> (r_total != '0), "drain running on an empty chain")
    `TKHS_ASSERT_RST(a_grow_count, i_clk, i_rst_n, w_do_grow |=> (r_total == $past(r_total) + CW'(1)), "insert into a free slot did not grow the fill count")
    `TKHS_ASSERT_RST(a_last_beat, i_clk, i_rst_n, (w_load && (r_total == CW'(1))) |=> (!r_draining && m_axis_tvalid && m_axis_tlast), "final drain beat not flagged or drain not ended")

endmodule
